>>> rtl/core/idf_pkg.sv
`default_nettype none
package idf_pkg;

    localparam int CONCEPTS   = 1024;
    localparam int TYPES      = 16;
    localparam int KINDS      = 5;
    localparam int COUNT_BITS = 20;
    localparam int FRAC_BITS  = 20;

    localparam int CID_BITS   = $clog2(CONCEPTS);
    localparam int TID_BITS   = $clog2(TYPES);
    localparam int KIND_BITS  = 3;
    localparam int CDEPTH     = KINDS * CONCEPTS;
    localparam int TDEPTH     = KINDS * TYPES;
    localparam int CADDR_BITS = $clog2(CDEPTH);
    localparam int TADDR_BITS = $clog2(TDEPTH);

    // per-object marks are epoch tags: a concept is seen when its tag equals the epoch
    localparam int EPOCH_BITS = 12;

    localparam int N_BITS     = 5;
    localparam int LOG_BITS   = N_BITS + FRAC_BITS;
    localparam int ITER_BITS  = $clog2(FRAC_BITS);

    localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
    localparam logic [15:0] LOG10_2_LO  = LOG10_2_Q32[15:0];
    localparam logic [15:0] LOG10_2_HI  = LOG10_2_Q32[31:16];

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic                 cmd;
        logic                 remove;
        logic                 first_of_object;
        logic [KIND_BITS-1:0] obj_kind;
        logic [9:0]           concept_id;
        logic [3:0]           type_id;
    } t_in_word;

    typedef struct packed {
        logic [15:0] idf;
        logic [19:0] concept_refs;
        logic [19:0] type_refs;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_NORM,
        ST_SQUARE,
        ST_REDUCE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_DONE
    } t_state;

    localparam logic CMD_REF   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage
`default_nettype wire

>>> rtl/core/idf_ram.sv
`default_nettype none
module idf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/idf_document_frequency_table.sv
// document-frequency table with inverse-frequency query
//
// input channel i_valid / o_ready carries one word: a concept reference of an
// object (add or remove) or a query. references update the per-kind concept
// and type counters, each at most once per object; first_of_object opens a
// new object. a query yields one output word on o_valid / i_ready holding
// log10(type count / concept count) in unsigned Q3.13 and both counters.
//
// one word is worked on at a time. a reference passes accept, read and write
// back through the counter memories. a query passes accept, read, then for
// each of the two counts a normalization step and 20 squaring steps, each
// a square and a reduce step on a shared 32x32 multiplier, then a low and a
// high multiply step and a scaling step by log10(2), and the load; a query
// with a zero count goes from the read straight to the load.
// after reset a clearing pass zeroes the counter memories while o_ready stays
// low. the seen marks are epoch tags; once every 4094 objects the epoch wraps
// and a pass clears them before the next first reference is taken.
// a finished result waits in the output register while the next word is
// accepted; a stalled receiver only holds a query at its last step.
`default_nettype none
module idf_document_frequency_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire idf_pkg::t_in_word i_in_word,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output idf_pkg::t_out_word     o_out_word
);

    localparam int CB = idf_pkg::COUNT_BITS;
    localparam int LB = idf_pkg::LOG_BITS;
    localparam int EB = idf_pkg::EPOCH_BITS;
    localparam logic [EB-1:0] EPOCH_MAX = {EB{1'b1}};

    idf_pkg::t_state r_state, n_state;
    idf_pkg::t_in_word r_item;

    logic [idf_pkg::CADDR_BITS-1:0] r_clr_idx;
    logic                           r_clr_all;
    logic [EB-1:0]                  r_epoch;
    logic [idf_pkg::TYPES-1:0]      r_seen_type;

    logic [CB-1:0] r_cc, r_tc;
    logic [31:0]   r_m;
    logic [63:0]   r_prod;
    logic [idf_pkg::N_BITS-1:0]    r_n;
    logic [idf_pkg::FRAC_BITS-1:0] r_frac;
    logic [idf_pkg::ITER_BITS-1:0] r_iter;
    logic          r_phase;
    logic [LB-1:0] r_lt, r_diff;
    logic [LB+15:0] r_plo, r_phi;
    logic [15:0]   r_idf;
    logic          r_ovalid;
    idf_pkg::t_out_word r_out;

    // memory ports
    logic                           c_we, t_we, s_we;
    logic [idf_pkg::CADDR_BITS-1:0] c_waddr, c_raddr;
    logic [idf_pkg::TADDR_BITS-1:0] t_waddr, t_raddr;
    logic [idf_pkg::CID_BITS-1:0]   s_waddr;
    logic [CB-1:0]                  c_wdata, c_rdata, t_wdata, t_rdata;
    logic [EB-1:0]                  s_wdata, s_rdata;

    logic in_take, wrap_block, kind_ok, item_kind_ok;
    logic c_seen, t_seen;
    logic [CB-1:0] c_bumped, t_bumped;
    logic [idf_pkg::CADDR_BITS-1:0] c_addr;
    logic [idf_pkg::TADDR_BITS-1:0] t_addr;
    logic [CB-1:0] q_cc, q_tc, norm_x;
    logic [idf_pkg::N_BITS-1:0] norm_n;
    logic [32:0] red_p;
    logic [idf_pkg::FRAC_BITS-1:0] red_frac;
    logic [LB-1:0] red_l;
    logic [LB+32:0] scale_sum;
    logic [LB+32-39:0] scale_q;
    logic out_load, clr_last;

    function automatic logic [CB-1:0] bump(input logic [CB-1:0] v, input logic down);
        logic [CB-1:0] r;
        if (down) begin
            r = (v == '0) ? '0 : v - 1'b1;
        end else begin
            r = (v == idf_pkg::COUNT_MAX) ? v : v + 1'b1;
        end
        return r;
    endfunction

    // a new object whose epoch would wrap waits for the marks to be cleared
    assign wrap_block = i_valid && (i_in_word.cmd == idf_pkg::CMD_REF)
                     && i_in_word.first_of_object
                     && (i_in_word.obj_kind < idf_pkg::KIND_BITS'(idf_pkg::KINDS))
                     && (r_epoch == EPOCH_MAX);
    assign in_take = i_valid && o_ready;

    assign item_kind_ok = r_item.obj_kind < idf_pkg::KIND_BITS'(idf_pkg::KINDS);
    assign kind_ok = item_kind_ok;
    assign c_addr = kind_ok ? {r_item.obj_kind, r_item.concept_id} : '0;
    assign t_addr = kind_ok ? idf_pkg::TADDR_BITS'({r_item.obj_kind, r_item.type_id}) : '0;

    assign c_seen   = (s_rdata == r_epoch);
    assign t_seen   = r_seen_type[r_item.type_id] && !r_item.first_of_object;
    assign c_bumped = bump(c_rdata, r_item.remove);
    assign t_bumped = bump(t_rdata, r_item.remove);
    assign q_cc     = kind_ok ? c_rdata : '0;
    assign q_tc     = kind_ok ? t_rdata : '0;

    assign clr_last = r_clr_all
        ? (r_clr_idx == idf_pkg::CADDR_BITS'(idf_pkg::CDEPTH - 1))
        : (r_clr_idx == idf_pkg::CADDR_BITS'(idf_pkg::CONCEPTS - 1));

    // leading-one search for the log normalization
    always_comb begin
        norm_x = r_phase ? r_cc : r_tc;
        norm_n = '0;
        for (int i = 0; i < CB; i++) begin
            if (norm_x[i]) begin
                norm_n = idf_pkg::N_BITS'(i);
            end
        end
    end

    // one squaring step: the carry out of [1,2) gives the next fraction bit
    assign red_p    = r_prod[63:31];
    assign red_frac = {r_frac[idf_pkg::FRAC_BITS-2:0], red_p[32]};
    assign red_l    = {r_n, red_frac};

    assign scale_sum = (LB+33)'(r_plo) + ((LB+33)'(r_phi) << 16) + ((LB+33)'(1) << 38);
    assign scale_q   = scale_sum[LB+32:39];

    assign out_load = (r_state == idf_pkg::ST_DONE) && (!r_ovalid || i_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            idf_pkg::ST_CLEAR:  if (clr_last) n_state = idf_pkg::ST_IDLE;
            idf_pkg::ST_IDLE: begin
                if (wrap_block) begin
                    n_state = idf_pkg::ST_CLEAR;
                end else if (i_valid) begin
                    n_state = idf_pkg::ST_READ;
                end
            end
            idf_pkg::ST_READ:   n_state = idf_pkg::ST_UPDATE;
            idf_pkg::ST_UPDATE: begin
                if (r_item.cmd == idf_pkg::CMD_REF) begin
                    n_state = idf_pkg::ST_IDLE;
                end else if (q_cc == '0 || q_tc == '0) begin
                    n_state = idf_pkg::ST_DONE;
                end else begin
                    n_state = idf_pkg::ST_NORM;
                end
            end
            idf_pkg::ST_NORM:   n_state = idf_pkg::ST_SQUARE;
            idf_pkg::ST_SQUARE: n_state = idf_pkg::ST_REDUCE;
            idf_pkg::ST_REDUCE: begin
                if (r_iter != idf_pkg::ITER_BITS'(idf_pkg::FRAC_BITS - 1)) begin
                    n_state = idf_pkg::ST_SQUARE;
                end else if (!r_phase) begin
                    n_state = idf_pkg::ST_NORM;
                end else if (r_lt <= red_l) begin
                    n_state = idf_pkg::ST_DONE;
                end else begin
                    n_state = idf_pkg::ST_MUL_LO;
                end
            end
            idf_pkg::ST_MUL_LO: n_state = idf_pkg::ST_MUL_HI;
            idf_pkg::ST_MUL_HI: n_state = idf_pkg::ST_SCALE;
            idf_pkg::ST_SCALE:  n_state = idf_pkg::ST_DONE;
            idf_pkg::ST_DONE:   if (out_load) n_state = idf_pkg::ST_IDLE;
            default:            n_state = idf_pkg::ST_CLEAR;
        endcase
    end

    // memory controls
    always_comb begin
        o_ready = 1'b0;
        c_we = 1'b0; t_we = 1'b0; s_we = 1'b0;
        c_waddr = c_addr; t_waddr = t_addr; s_waddr = r_item.concept_id;
        c_wdata = c_bumped; t_wdata = t_bumped; s_wdata = r_epoch;
        c_raddr = c_addr; t_raddr = t_addr;
        unique case (r_state)
            idf_pkg::ST_CLEAR: begin
                c_we    = r_clr_all;
                t_we    = r_clr_all && (r_clr_idx < idf_pkg::CADDR_BITS'(idf_pkg::TDEPTH));
                s_we    = r_clr_idx < idf_pkg::CADDR_BITS'(idf_pkg::CONCEPTS);
                c_waddr = r_clr_idx;
                t_waddr = r_clr_idx[idf_pkg::TADDR_BITS-1:0];
                s_waddr = r_clr_idx[idf_pkg::CID_BITS-1:0];
                c_wdata = '0; t_wdata = '0; s_wdata = '0;
            end
            idf_pkg::ST_IDLE:  o_ready = !wrap_block;
            idf_pkg::ST_UPDATE: begin
                if (r_item.cmd == idf_pkg::CMD_REF && kind_ok) begin
                    c_we = !c_seen;
                    s_we = !c_seen;
                    t_we = !t_seen;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= idf_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_clr_all   <= 1'b1;
            r_epoch     <= '0;
            r_seen_type <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == idf_pkg::ST_CLEAR) begin
                r_clr_idx <= clr_last ? '0 : r_clr_idx + 1'b1;
                if (clr_last) begin
                    // cleared tags are zero, so the live epoch must not be
                    r_clr_all <= 1'b0;
                    r_epoch   <= EB'(1);
                end
            end
            if (r_state == idf_pkg::ST_IDLE && wrap_block) begin
                r_clr_all <= 1'b0;
            end
            if (in_take && i_in_word.cmd == idf_pkg::CMD_REF && i_in_word.first_of_object
                && i_in_word.obj_kind < idf_pkg::KIND_BITS'(idf_pkg::KINDS)) begin
                r_epoch <= r_epoch + 1'b1;
            end
            if (r_state == idf_pkg::ST_UPDATE && r_item.cmd == idf_pkg::CMD_REF && kind_ok) begin
                if (r_item.first_of_object) begin
                    r_seen_type <= idf_pkg::TYPES'(1) << r_item.type_id;
                end else begin
                    r_seen_type[r_item.type_id] <= 1'b1;
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_word;
        end
        unique case (r_state)
            idf_pkg::ST_UPDATE: begin
                r_cc    <= q_cc;
                r_tc    <= q_tc;
                r_phase <= 1'b0;
                r_idf   <= '0;
            end
            idf_pkg::ST_NORM: begin
                r_m    <= 32'(norm_x) << (5'd31 - norm_n);
                r_n    <= norm_n;
                r_frac <= '0;
                r_iter <= '0;
            end
            idf_pkg::ST_SQUARE: r_prod <= r_m * r_m;
            idf_pkg::ST_REDUCE: begin
                r_m    <= red_p[32] ? red_p[32:1] : red_p[31:0];
                r_frac <= red_frac;
                r_iter <= r_iter + 1'b1;
                if (r_iter == idf_pkg::ITER_BITS'(idf_pkg::FRAC_BITS - 1)) begin
                    r_lt    <= red_l;
                    r_phase <= 1'b1;
                    r_diff  <= r_lt - red_l;
                end
            end
            idf_pkg::ST_MUL_LO: r_plo <= r_diff * idf_pkg::LOG10_2_LO;
            idf_pkg::ST_MUL_HI: r_phi <= r_diff * idf_pkg::LOG10_2_HI;
            idf_pkg::ST_SCALE: begin
                r_idf <= (scale_q > (LB-6)'(16'hffff)) ? 16'hffff : scale_q[15:0];
            end
            default: ;
        endcase
        if (out_load) begin
            r_out.idf          <= r_idf;
            r_out.concept_refs <= r_cc[19:0];
            r_out.type_refs    <= r_tc[19:0];
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_word = r_out;

    idf_ram #(.WIDTH(CB), .DEPTH(idf_pkg::CDEPTH)) u_concept_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    idf_ram #(.WIDTH(CB), .DEPTH(idf_pkg::TDEPTH)) u_type_ram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    idf_ram #(.WIDTH(EB), .DEPTH(idf_pkg::CONCEPTS)) u_seen_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(r_item.concept_id), .o_rdata(s_rdata)
    );

    // words are only taken when the engine is free
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == idf_pkg::ST_IDLE))
        else $error("input taken while busy");

    // a new object never starts on a full epoch
    a_epoch_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in_word.cmd == idf_pkg::CMD_REF && i_in_word.first_of_object
         && i_in_word.obj_kind < idf_pkg::KIND_BITS'(idf_pkg::KINDS))
        |-> (r_epoch != EPOCH_MAX))
        else $error("epoch wrapped inside an object");

    // a loaded result shows on the output in the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("result lost");

    // the log loop never runs past its fraction bits
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == idf_pkg::ST_REDUCE)
        |-> (r_iter <= idf_pkg::ITER_BITS'(idf_pkg::FRAC_BITS - 1)))
        else $error("log iteration overrun");

endmodule
`default_nettype wire
